// ===== hw/rtl/ptw_pkg.sv =====
package ptw_pkg;

   localparam int STORE_WORDS_DEF = 4096;
   localparam int VA_W            = 64;
   localparam int PA_W            = 48;
   localparam int DESC_W          = 64;
   localparam int SIDX_W          = 12;
   localparam int TBL_W           = 36;
   localparam int IDX_W           = 9;
   localparam int CSR_ADDR_W      = 2;

   typedef enum logic {
      ACT_WRITE = 1'b0,
      ACT_XLATE = 1'b1
   } action_type;

   typedef enum logic [CSR_ADDR_W-1:0] {
      CSR_KERNEL_ROOT  = 2'd0,
      CSR_USER_ROOT    = 2'd1,
      CSR_KERNEL_SPLIT = 2'd2,
      CSR_NONE         = 2'd3
   } csr_addr_type;

   localparam int DESC_VALID_BIT = 0;
   localparam int DESC_TABLE_BIT = 1;

   localparam logic [1:0] LVL_TOP  = 2'd0;
   localparam logic [1:0] LVL_ONE  = 2'd1;
   localparam logic [1:0] LVL_MID  = 2'd2;
   localparam logic [1:0] LVL_LAST = 2'd3;

   // 9-bit table index of a virtual address at one walk level
   function automatic logic [IDX_W-1:0] va_index(input logic [PA_W-1:0] va,
                                                  input logic [1:0] lvl);
      logic [IDX_W-1:0] idx;
      case (lvl)
         LVL_TOP:  idx = va[47:39];
         LVL_ONE:  idx = va[38:30];
         LVL_MID:  idx = va[29:21];
         default:  idx = va[20:12];
      endcase
      return idx;
   endfunction

endpackage

// ===== hw/rtl/ptw_ram.sv =====
module ptw_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 4096
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== hw/rtl/page_table_walker_4k_4level.sv =====
// Four-level page table walker, 4 KiB granule, with a local descriptor store.
// Input channel req_*: a beat with req_action write puts req_store_value into
// the store at req_store_index (modulo the store depth) and gives no result.
// A beat with req_action translate walks from the kernel root when
// req_virt_addr is at or above the split register, else from the user root,
// and gives one rsp_* beat: rsp_phys_addr and rsp_fault (address 0 on fault).
// The csr_* port writes kernel_root (0), user_root (1) and kernel_split (2).
// A translate beat steps through ST_READ, ST_CHECK (held while the walk descends
// a level) and ST_DONE, paced by the dependent descriptor reads from the store's
// single registered read port. req_ready is low while a walk is under way.
// The result sits in an output register; the next beat is accepted while it
// waits, and a finished walk holds until rsp_ready frees the register.
// After reset the block clears all STORE_WORDS words of the store (4096 by
// default), one word a cycle, with req_ready low; csr writes are taken
// throughout.
module page_table_walker_4k_4level
   import ptw_pkg::*;
#(
   parameter int STORE_WORDS = STORE_WORDS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic                  req_action,
   input  logic [SIDX_W-1:0]     req_store_index,
   input  logic [DESC_W-1:0]     req_store_value,
   input  logic [VA_W-1:0]       req_virt_addr,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic [PA_W-1:0]       rsp_phys_addr,
   output logic                  rsp_fault,
   input  logic                  csr_wr_en,
   input  logic [CSR_ADDR_W-1:0] csr_index,
   input  logic [DESC_W-1:0]     csr_wdata
);

   localparam int AW = $clog2(STORE_WORDS);

   typedef enum logic [4:0] {
      ST_CLEAR = 5'b00001,
      ST_IDLE  = 5'b00010,
      ST_READ  = 5'b00100,
      ST_CHECK = 5'b01000,
      ST_DONE  = 5'b10000
   } state_type;

   state_type        state_ff, state_in;
   logic [AW-1:0]    clr_ff, clr_in;
   logic [PA_W-1:0]  kroot_ff, uroot_ff;
   logic [VA_W-1:0]  split_ff;
   logic [PA_W-1:0]  va_ff, va_in;
   logic [TBL_W-1:0] table_ff, table_in;
   logic [1:0]       level_ff, level_in;
   logic [PA_W-1:0]  res_pa_ff, res_pa_in;
   logic             res_fault_ff, res_fault_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic [PA_W-1:0]  rsp_pa_ff, rsp_pa_in;
   logic             rsp_fault_ff, rsp_fault_in;

   logic                  req_fire;
   logic [AW+SIDX_W-1:0]  widx_wide;
   logic [TBL_W+IDX_W-1:0] rd_word_wide;
   logic                  ram_we;
   logic [AW-1:0]         ram_waddr;
   logic [DESC_W-1:0]     ram_wdata;
   logic [AW-1:0]         ram_raddr;
   logic [DESC_W-1:0]     desc;
   logic [1:0]            level_nx;
   logic                  out_free;

   assign req_ready = (state_ff == ST_IDLE);
   assign req_fire  = req_valid && req_ready;
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign level_nx  = level_ff + 2'd1;
   assign widx_wide = {{AW{1'b0}}, req_store_index};

   always_comb begin
      if (state_ff == ST_CLEAR) begin
         ram_we    = 1'b1;
         ram_waddr = clr_ff;
         ram_wdata = '0;
      end else begin
         ram_we    = req_fire && (req_action == ACT_WRITE);
         ram_waddr = widx_wide[AW-1:0];
         ram_wdata = req_store_value;
      end
   end

   // table base has bits 11:0 clear, so the word index is base[47:12] joined with idx
   always_comb begin
      if (state_ff == ST_CHECK) begin
         rd_word_wide = {desc[47:12], va_index(va_ff, level_nx)};
      end else begin
         rd_word_wide = {table_ff, va_index(va_ff, level_ff)};
      end
   end
   assign ram_raddr = rd_word_wide[AW-1:0];

   ptw_ram #(
      .WIDTH (DESC_W),
      .DEPTH (STORE_WORDS)
   ) u_store (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_addr (ram_raddr),
      .rd_data (desc)
   );

   always_comb begin
      state_in     = state_ff;
      clr_in       = clr_ff;
      va_in        = va_ff;
      table_in     = table_ff;
      level_in     = level_ff;
      res_pa_in    = res_pa_ff;
      res_fault_in = res_fault_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_pa_in    = rsp_pa_ff;
      rsp_fault_in = rsp_fault_ff;
      unique case (state_ff)
         ST_CLEAR: begin
            clr_in = clr_ff + AW'(1);
            if (clr_ff == {AW{1'b1}}) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_fire && (req_action == ACT_XLATE)) begin
               va_in    = req_virt_addr[PA_W-1:0];
               level_in = LVL_TOP;
               table_in = (req_virt_addr >= split_ff) ? kroot_ff[47:12] : uroot_ff[47:12];
               state_in = ST_READ;
            end
         end
         ST_READ: begin
            state_in = ST_CHECK;
         end
         ST_CHECK: begin
            if (!desc[DESC_VALID_BIT]) begin
               res_pa_in    = '0;
               res_fault_in = 1'b1;
               state_in     = ST_DONE;
            end else if (level_ff == LVL_LAST) begin
               res_pa_in    = {desc[47:12], va_ff[11:0]};
               res_fault_in = 1'b0;
               state_in     = ST_DONE;
            end else if (!desc[DESC_TABLE_BIT]) begin
               res_fault_in = 1'b0;
               if (level_ff == LVL_MID) begin
                  res_pa_in = {desc[47:21], va_ff[20:0]};
               end else begin
                  res_pa_in = {desc[47:30], va_ff[29:0]};
               end
               state_in = ST_DONE;
            end else begin
               level_in = level_nx;
            end
         end
         ST_DONE: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_pa_in    = res_pa_ff;
               rsp_fault_in = res_fault_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         kroot_ff     <= '0;
         uroot_ff     <= '0;
         split_ff     <= '0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_wr_en) begin
            unique case (csr_index)
               CSR_KERNEL_ROOT:  kroot_ff <= csr_wdata[PA_W-1:0];
               CSR_USER_ROOT:    uroot_ff <= csr_wdata[PA_W-1:0];
               CSR_KERNEL_SPLIT: split_ff <= csr_wdata;
               default: begin
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      va_ff        <= va_in;
      table_ff     <= table_in;
      level_ff     <= level_in;
      res_pa_ff    <= res_pa_in;
      res_fault_ff <= res_fault_in;
      rsp_pa_ff    <= rsp_pa_in;
      rsp_fault_ff <= rsp_fault_in;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_phys_addr = rsp_pa_ff;
   assign rsp_fault     = rsp_fault_ff;

endmodule

// ===== verif/ptw_xlate_checker.sv =====
`timescale 1ns / 100ps

module ptw_xlate_checker
   import ptw_pkg::*;
#(
   parameter int STORE_WORDS = STORE_WORDS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   input  logic                  req_ready,
   input  logic                  req_action,
   input  logic [SIDX_W-1:0]     req_store_index,
   input  logic [DESC_W-1:0]     req_store_value,
   input  logic [VA_W-1:0]       req_virt_addr,
   input  logic                  rsp_valid,
   input  logic                  rsp_ready,
   input  logic [PA_W-1:0]       rsp_phys_addr,
   input  logic                  rsp_fault,
   input  logic                  csr_wr_en,
   input  logic [CSR_ADDR_W-1:0] csr_index,
   input  logic [DESC_W-1:0]     csr_wdata,
   output int                    fail_count,
   output int                    pending
);

   typedef struct packed {
      logic [PA_W-1:0] phys_addr;
      logic            fault;
   } xlate_result_type;

   logic [DESC_W-1:0] desc_mirror [STORE_WORDS];
   logic [PA_W-1:0]   kernel_root_q;
   logic [PA_W-1:0]   user_root_q;
   logic [VA_W-1:0]   kernel_split_q;
   xlate_result_type  expected_xlates [$];
   int                n_fail;

   initial begin
      fail_count = 0;
      pending    = 0;
      n_fail     = 0;
   end

   function automatic xlate_result_type translate_va(input logic [VA_W-1:0] va);
      logic [PA_W-1:0]   tbl;
      logic [DESC_W-1:0] d;
      xlate_result_type  r;
      int                lvl;
      tbl = (va >= kernel_split_q) ? kernel_root_q : user_root_q;
      tbl[11:0] = '0;
      r = '0;
      for (lvl = 0; lvl < 4; lvl++) begin
         d = desc_mirror[((tbl >> 3) + va[39 - 9 * lvl +: IDX_W]) % STORE_WORDS];
         if (!d[DESC_VALID_BIT]) begin
            r.fault = 1'b1;
            return r;
         end
         if (lvl == int'(LVL_LAST)) begin
            r.phys_addr = {d[47:12], va[11:0]};
            return r;
         end
         if (!d[DESC_TABLE_BIT]) begin
            if (lvl == int'(LVL_MID)) begin
               r.phys_addr = {d[47:21], va[20:0]};
            end else begin
               r.phys_addr = {d[47:30], va[29:0]};
            end
            return r;
         end
         tbl = {d[47:12], 12'h000};
      end
      return r;
   endfunction

   always @(posedge clock) begin
      xlate_result_type want;
      int               w;
      if (reset) begin
         for (w = 0; w < STORE_WORDS; w++) begin
            desc_mirror[w] = '0;
         end
         kernel_root_q  = '0;
         user_root_q    = '0;
         kernel_split_q = '0;
         expected_xlates.delete();
      end else begin
         // result beat first: it can never belong to a request taken at this edge
         if (rsp_valid && rsp_ready) begin
            if (expected_xlates.size() == 0) begin
               $error("result beat with nothing expected: phys_addr %h fault %b",
                      rsp_phys_addr, rsp_fault);
               n_fail++;
            end else begin
               want = expected_xlates.pop_front();
               if (rsp_phys_addr !== want.phys_addr) begin
                  $error("phys_addr mismatch: expected %h, actual %h",
                         want.phys_addr, rsp_phys_addr);
                  n_fail++;
               end
               if (rsp_fault !== want.fault) begin
                  $error("fault mismatch: expected %b, actual %b", want.fault, rsp_fault);
                  n_fail++;
               end
            end
         end
         if (req_valid && req_ready) begin
            if (req_action == ACT_XLATE) begin
               expected_xlates.push_back(translate_va(req_virt_addr));
            end else begin
               desc_mirror[req_store_index % STORE_WORDS] = req_store_value;
            end
         end
         if (csr_wr_en) begin
            case (csr_addr_type'(csr_index))
               CSR_KERNEL_ROOT:  kernel_root_q  = csr_wdata[PA_W-1:0];
               CSR_USER_ROOT:    user_root_q    = csr_wdata[PA_W-1:0];
               CSR_KERNEL_SPLIT: kernel_split_q = csr_wdata;
               default: ;
            endcase
         end
      end
      fail_count <= n_fail;
      pending    <= expected_xlates.size();
   end

endmodule

// ===== verif/tb_page_table_walker_4k_4level.sv =====
`timescale 1ns / 100ps

module tb_page_table_walker_4k_4level;
   import ptw_pkg::*;

   localparam int STALL_LIMIT    = 20000;
   localparam int SETTLE_CYCLES  = 10;
   localparam int RAND_PER_PHASE = 325;
   localparam int N_PHASES       = 5;

   typedef enum int {
      END_FAULT,
      END_BLOCK,
      END_PAGE
   } walk_end_type;

   logic                  clock;
   logic                  reset;
   logic                  req_valid;
   logic                  req_ready;
   logic                  req_action;
   logic [SIDX_W-1:0]     req_store_index;
   logic [DESC_W-1:0]     req_store_value;
   logic [VA_W-1:0]       req_virt_addr;
   logic                  rsp_valid;
   logic                  rsp_ready;
   logic [PA_W-1:0]       rsp_phys_addr;
   logic                  rsp_fault;
   logic                  csr_wr_en;
   logic [CSR_ADDR_W-1:0] csr_index;
   logic [DESC_W-1:0]     csr_wdata;

   int                    fail_count;
   int                    pending;
   int                    idle_pct = 36;
   int                    stall_cycles = 0;
   int                    n_writes = 0;
   int                    n_xlates = 0;
   logic [PA_W-1:0]       kroot_cfg = '0;
   logic [PA_W-1:0]       uroot_cfg = '0;
   logic [VA_W-1:0]       split_cfg = '0;

   page_table_walker_4k_4level u_top (.*);

   ptw_xlate_checker u_checker (.*);

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   always @(negedge clock) begin
      rsp_ready <= ($urandom_range(99) >= idle_pct);
   end

   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         stall_cycles <= 0;
      end else if (stall_cycles >= STALL_LIMIT) begin
         $display("watchdog: no beat moved for %0d cycles", stall_cycles);
         $display("Simulation FAILED");
         $finish;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
   end

   function automatic logic [63:0] rand64();
      return {$urandom, $urandom};
   endfunction

   function automatic logic [VA_W-1:0] pick_va();
      logic [VA_W-1:0] v;
      v = rand64();
      case ($urandom_range(3))
         0: v[63:48] = '1;
         1: v[63:48] = '0;
         2: v = split_cfg - $urandom_range(1);
         default: ;
      endcase
      return v;
   endfunction

   task automatic csr_write(input csr_addr_type idx, input logic [DESC_W-1:0] data);
      @(negedge clock);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      case (idx)
         CSR_KERNEL_ROOT:  kroot_cfg = data[PA_W-1:0];
         CSR_USER_ROOT:    uroot_cfg = data[PA_W-1:0];
         CSR_KERNEL_SPLIT: split_cfg = data;
         default: ;
      endcase
      @(negedge clock);
      csr_wr_en <= 1'b0;
   endtask

   task automatic send_beat(input action_type act, input logic [SIDX_W-1:0] idx,
                            input logic [DESC_W-1:0] val, input logic [VA_W-1:0] va);
      @(negedge clock);
      while ($urandom_range(99) < idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid       <= 1'b1;
      req_action      <= act;
      req_store_index <= idx;
      req_store_value <= val;
      req_virt_addr   <= va;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      if (act == ACT_XLATE) n_xlates++;
      else n_writes++;
   endtask

   // lay down descriptors along the path of va, then translate it
   task automatic build_walk(input logic [VA_W-1:0] va, input int stop_lvl,
                             input walk_end_type how);
      logic [PA_W-1:0]   tbl;
      logic [DESC_W-1:0] d;
      int                lvl;
      tbl = (va >= split_cfg) ? kroot_cfg : uroot_cfg;
      tbl[11:0] = '0;
      for (lvl = 0; lvl <= stop_lvl; lvl++) begin
         d = rand64();
         if (lvl < stop_lvl) begin
            d[DESC_VALID_BIT] = 1'b1;
            d[DESC_TABLE_BIT] = 1'b1;
         end else begin
            case (how)
               END_FAULT: d[DESC_VALID_BIT] = 1'b0;
               END_BLOCK: begin
                  d[DESC_VALID_BIT] = 1'b1;
                  d[DESC_TABLE_BIT] = 1'b0;
               end
               default: begin
                  d[DESC_VALID_BIT] = 1'b1;
                  d[DESC_TABLE_BIT] = 1'b1;
               end
            endcase
         end
         send_beat(ACT_WRITE, SIDX_W'((tbl >> 3) + va[39 - 9 * lvl +: IDX_W]), d, rand64());
         tbl = {d[47:12], 12'h000};
      end
      send_beat(ACT_XLATE, SIDX_W'($urandom), rand64(), va);
   endtask

   initial begin
      int              phase;
      int              goal;
      int              r;
      int              lvl;
      walk_end_type    how;
      logic [VA_W-1:0] va;

      reset           = 1'b1;
      req_valid       = 1'b0;
      req_action      = ACT_WRITE;
      req_store_index = '0;
      req_store_value = '0;
      req_virt_addr   = '0;
      rsp_ready       = 1'b0;
      csr_wr_en       = 1'b0;
      csr_index       = CSR_NONE;
      csr_wdata       = '0;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      for (phase = 0; phase < N_PHASES; phase++) begin
         idle_pct = (phase == 2) ? 0 : 36;
         case (phase)
            0: begin
               csr_write(CSR_KERNEL_ROOT, 64'h0000_0000_0004_0000);
               csr_write(CSR_USER_ROOT, 64'h0000_0000_0000_1000);
               csr_write(CSR_KERNEL_SPLIT, 64'hFFFF_0000_0000_0000);
            end
            1: begin
               csr_write(CSR_KERNEL_ROOT, '1);
               csr_write(CSR_USER_ROOT, '0);
               csr_write(CSR_KERNEL_SPLIT, '0);
            end
            2: begin
               csr_write(CSR_KERNEL_ROOT, rand64());
               csr_write(CSR_USER_ROOT, rand64());
               csr_write(CSR_KERNEL_SPLIT, '1);
               csr_write(CSR_NONE, rand64());
            end
            3: begin
               csr_write(CSR_KERNEL_ROOT, rand64());
               csr_write(CSR_USER_ROOT, rand64());
               csr_write(CSR_KERNEL_SPLIT, rand64());
            end
            default: begin
               csr_write(CSR_KERNEL_ROOT, '0);
               csr_write(CSR_USER_ROOT, '1);
               csr_write(CSR_KERNEL_SPLIT, 64'h0000_8000_0000_0000);
            end
         endcase

         if (phase == 0) begin
            // empty store faults at the first level on both roots
            send_beat(ACT_XLATE, '0, '0, '0);
            send_beat(ACT_XLATE, '1, '1, '1);
            send_beat(ACT_WRITE, '1, '1, '0);
            send_beat(ACT_WRITE, '0, '0, '1);
            build_walk(64'hFFFF_8040_2010_0ABC, 0, END_BLOCK);
            build_walk(64'h0000_1234_5678_9ABC, 1, END_BLOCK);
            build_walk(64'hFFFF_FF80_3FE0_1FFF, 2, END_BLOCK);
            // last level page with the table bit clear
            build_walk(64'h0000_7FFF_FFFF_FFFF, 3, END_BLOCK);
            build_walk(64'hFFFF_0000_0000_0000, 3, END_FAULT);
         end else begin
            goal = n_writes + n_xlates + RAND_PER_PHASE;
            while (n_writes + n_xlates < goal) begin
               r = $urandom_range(99);
               if (r < 72) begin
                  lvl = $urandom_range(3);
                  how = walk_end_type'($urandom_range(2));
                  if (how == END_PAGE && lvl != 3) how = END_BLOCK;
                  va = pick_va();
                  build_walk(va, lvl, how);
                  if ($urandom_range(1)) begin
                     send_beat(ACT_XLATE, SIDX_W'($urandom), rand64(),
                               va ^ {34'd0, 30'($urandom)});
                  end
               end else if (r < 88) begin
                  send_beat(ACT_WRITE, SIDX_W'($urandom), rand64(), rand64());
               end else begin
                  send_beat(ACT_XLATE, SIDX_W'($urandom), rand64(), pick_va());
               end
            end
         end

         // hold the sender until every translation has come back
         @(negedge clock);
         req_valid <= 1'b0;
         while (pending != 0) @(posedge clock);
         repeat (SETTLE_CYCLES) @(posedge clock);
      end

      $display("covered %0d descriptor writes and %0d translations over %0d register settings",
               n_writes, n_xlates, N_PHASES);
      $display("walks ended in faults, 1 GiB and 2 MiB blocks and 4 KiB pages on both roots");
      if (fail_count == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule

// ===== filelist.f =====
hw/rtl/ptw_pkg.sv
hw/rtl/ptw_ram.sv
hw/rtl/page_table_walker_4k_4level.sv
verif/ptw_xlate_checker.sv
verif/tb_page_table_walker_4k_4level.sv
